/* src/lc3b_pkg.sv */
// lc3b core package: item codes, instruction opcodes, result type
package lc3b_pkg;
	localparam logic [1:0] ITEM_WRITE   = 2'd0;
	localparam logic [1:0] ITEM_READ    = 2'd1;
	localparam logic [1:0] ITEM_RESTART = 2'd2;
	localparam logic [1:0] ITEM_EXEC    = 2'd3;

	localparam logic [3:0] OP_BR   = 4'd0;
	localparam logic [3:0] OP_ADD  = 4'd1;
	localparam logic [3:0] OP_LDB  = 4'd2;
	localparam logic [3:0] OP_STB  = 4'd3;
	localparam logic [3:0] OP_JSR  = 4'd4;
	localparam logic [3:0] OP_AND  = 4'd5;
	localparam logic [3:0] OP_LDW  = 4'd6;
	localparam logic [3:0] OP_STW  = 4'd7;
	localparam logic [3:0] OP_XOR  = 4'd9;
	localparam logic [3:0] OP_JMP  = 4'd12;
	localparam logic [3:0] OP_SHF  = 4'd13;
	localparam logic [3:0] OP_LEA  = 4'd14;
	localparam logic [3:0] OP_TRAP = 4'd15;

	localparam logic [2:0] CC_RESET = 3'b010;

	typedef struct packed {
		logic [15:0] program_counter;
		logic [2:0]  cond_codes;
		logic        halted;
		logic        reg_written;
		logic [2:0]  reg_index;
		logic [15:0] reg_value;
		logic        mem_stored;
		logic [15:0] read_word;
	} result_t;

	function automatic logic [2:0] cc_of(input logic [15:0] r);
		logic [2:0] c;
		if (r == 16'h0000) c = 3'b010;
		else if (r[15]) c = 3'b100;
		else c = 3'b001;
		return c;
	endfunction
endpackage

/* src/lc3b_ram.sv */
// generic single-port ram with registered read
module lc3b_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

/* src/lc3b_instruction_execute.sv */
// lc3b core top level: memory sequencer, register file, execute logic
// Usage:
// One request enters on valid/stall with opcode, word_address and write_word;
// one result leaves on out_valid/out_stall. start_pc is set over the APB
// port at address 0; the user sets it only while the core is idle, which the core does not enforce.
// A read request passes the read state into the output register; a write,
// restart or halted execute goes straight into it; an instruction runs fetch read,
// operand or data read and writeback, with a read-modify-write added for byte stores.
// All accesses go through one single-port memory; that port sets the rate.
// A new request is accepted as soon as the sequencer is free and the output
// register is empty or being taken, so a finished result never waits while the
// next request is accepted.
// After reset the core sweeps the memory to zero, one word a cycle, through all
// MEM_WORDS words, and accepts no request then; APB writes still work.
// Registers read as zero, PC is zero, flags are Z.
// When out_stall is high the result holds and the next request waits.
module lc3b_instruction_execute
	import lc3b_pkg::*;
#(
	parameter int MEM_WORDS = 32768
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [14:0] word_address,
	input  logic [15:0] write_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] program_counter,
	output logic [2:0]  cond_codes,
	output logic        halted,
	output logic        reg_written,
	output logic [2:0]  reg_index,
	output logic [15:0] reg_value,
	output logic        mem_stored,
	output logic [15:0] read_word
);
	localparam int AW = $clog2(MEM_WORDS);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_RDW   = 3'd2;
	localparam logic [2:0] ST_FETCH = 3'd3;
	localparam logic [2:0] ST_DATA  = 3'd4;
	localparam logic [2:0] ST_LOAD  = 3'd5;
	localparam logic [2:0] ST_RMW   = 3'd6;

	logic [2:0]    state_q;
	logic [AW:0]   clr_q;
	logic [15:0]   start_pc_q;
	logic [15:0]   pc_q;
	logic [2:0]    cc_q;
	logic [15:0]   rf_q [8];
	logic [15:0]   ir_q;
	logic [15:0]   addr_q;
	logic [15:0]   inc_q;
	logic          out_valid_q;
	result_t       res_q;
	result_t       nres;
	logic          load_out;

	logic          we;
	logic [AW-1:0] ma;
	logic [15:0]   wd;
	logic [15:0]   rdat;

	lc3b_ram #(.WIDTH(16), .DEPTH(MEM_WORDS)) u_ram (
		.clk(clk), .we(we), .addr(ma), .wdata(wd), .rdata(rdat)
	);

	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? {16'h0000, start_pc_q} : 32'h0;

	wire out_free = !out_valid_q || !out_stall;
	assign in_stall = !(state_q == ST_IDLE && out_free);
	wire acc = in_valid && !in_stall;

	// decode of held instruction
	wire [3:0]  opc  = ir_q[15:12];
	wire [2:0]  dr   = ir_q[11:9];
	wire [15:0] a    = rf_q[ir_q[8:6]];
	wire [15:0] s6   = {{10{ir_q[5]}}, ir_q[5:0]};
	wire [15:0] s5   = {{11{ir_q[4]}}, ir_q[4:0]};
	wire [15:0] s9x2 = {{6{ir_q[8]}}, ir_q[8:0], 1'b0};
	wire [15:0] s11x2 = {{4{ir_q[10]}}, ir_q[10:0], 1'b0};
	wire [15:0] bop  = ir_q[5] ? s5 : rf_q[ir_q[2:0]];

	// data address for the fetched word (rdat in ST_FETCH)
	wire [3:0]  fopc = rdat[15:12];
	wire [15:0] fa   = rf_q[rdat[8:6]];
	wire [15:0] fs6  = {{10{rdat[5]}}, rdat[5:0]};
	wire [15:0] fbyte = fa + fs6;
	wire [15:0] fword = fa + {fs6[14:0], 1'b0};
	wire [15:0] faddr = (fopc == OP_LDB || fopc == OP_STB) ? fbyte :
		(fopc == OP_TRAP) ? {7'd0, rdat[7:0], 1'b0} : fword;

	logic [15:0] shv;
	always_comb begin
		if (!ir_q[4]) shv = a << ir_q[3:0];
		else if (!ir_q[5]) shv = a >> ir_q[3:0];
		else shv = 16'($signed(a) >>> ir_q[3:0]);
	end

	wire [15:0] ldb = addr_q[0] ? {{8{rdat[15]}}, rdat[15:8]} : {{8{rdat[7]}}, rdat[7:0]};

	// result of an instruction in ST_DATA (rdat holds the data word)
	logic [15:0] xres, xnpc;
	logic        xrw, xcc, xms;
	logic [2:0]  xdr;
	always_comb begin
		xres = 16'h0; xnpc = inc_q; xrw = 1'b0; xcc = 1'b0; xms = 1'b0; xdr = dr;
		case (opc)
			OP_BR: if ((dr & cc_q) != 3'd0) xnpc = inc_q + s9x2;
			OP_ADD: begin xres = a + bop; xrw = 1'b1; xcc = 1'b1; end
			OP_AND: begin xres = a & bop; xrw = 1'b1; xcc = 1'b1; end
			OP_XOR: begin xres = a ^ bop; xrw = 1'b1; xcc = 1'b1; end
			OP_LDB: begin xres = ldb; xrw = 1'b1; xcc = 1'b1; end
			OP_LDW: begin xres = rdat; xrw = 1'b1; xcc = 1'b1; end
			OP_STB, OP_STW: xms = 1'b1;
			OP_JSR: begin
				xnpc = ir_q[11] ? inc_q + s11x2 : a;
				xdr = 3'd7; xres = inc_q; xrw = 1'b1;
			end
			OP_JMP: xnpc = a;
			OP_SHF: begin xres = shv; xrw = 1'b1; xcc = 1'b1; end
			OP_LEA: begin xres = inc_q + s9x2; xrw = 1'b1; end
			OP_TRAP: begin xnpc = rdat; xdr = 3'd7; xres = inc_q; xrw = 1'b1; end
			default: xnpc = pc_q;
		endcase
	end

	wire [15:0] stb_word = addr_q[0] ? {rf_q[dr][7:0], rdat[7:0]} :
		{rdat[15:8], rf_q[dr][7:0]};

	// memory port and result assembly
	always_comb begin
		we = 1'b0; ma = pc_q[AW:1]; wd = rf_q[dr];
		load_out = 1'b0;
		nres = '0;
		nres.program_counter = pc_q;
		nres.cond_codes = cc_q;
		case (state_q)
			ST_CLEAR: begin we = 1'b1; ma = clr_q[AW-1:0]; wd = 16'h0; end
			ST_IDLE: if (acc) begin
				ma = (opcode == ITEM_EXEC) ? pc_q[AW:1] : word_address[AW-1:0];
				we = (opcode == ITEM_WRITE);
				wd = write_word;
				if (opcode == ITEM_WRITE) begin
					load_out = 1'b1;
				end else if (opcode == ITEM_RESTART) begin
					load_out = 1'b1;
					nres.program_counter = {start_pc_q[15:1], 1'b0};
				end else if (opcode == ITEM_EXEC && pc_q == 16'h0) begin
					load_out = 1'b1;
					nres.halted = 1'b1;
				end
			end
			ST_RDW: begin
				load_out = 1'b1;
				nres.read_word = rdat;
			end
			ST_FETCH: ma = faddr[AW:1];
			ST_DATA: begin
				ma = addr_q[AW:1];
				if (opc == OP_STW) we = 1'b1;
				if (opc != OP_STB) begin
					load_out = 1'b1;
					nres.program_counter = xnpc;
					if (xcc) nres.cond_codes = cc_of(xres);
					nres.reg_written = xrw;
					nres.reg_index = xrw ? xdr : 3'd0;
					nres.reg_value = xrw ? xres : 16'h0;
					nres.mem_stored = xms;
				end
			end
			ST_RMW: begin
				ma = addr_q[AW:1];
				we = 1'b1;
				wd = stb_word;
				load_out = 1'b1;
				nres.program_counter = inc_q;
				nres.mem_stored = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			start_pc_q <= 16'h0;
			pc_q <= 16'h0;
			cc_q <= CC_RESET;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 8; i++) rf_q[i] <= 16'h0;
		end else begin
			if (psel && penable && pwrite && paddr == 2'd0) start_pc_q <= pwdata[15:0];
			out_valid_q <= load_out || (out_valid_q && out_stall);
			if (load_out) begin
				pc_q <= nres.program_counter;
				cc_q <= nres.cond_codes;
				if (nres.reg_written) rf_q[nres.reg_index] <= nres.reg_value;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (AW+1)'(MEM_WORDS - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: if (acc) begin
					case (opcode)
						ITEM_READ: state_q <= ST_RDW;
						ITEM_EXEC: if (pc_q != 16'h0) state_q <= ST_FETCH;
						default: ;
					endcase
				end
				ST_RDW: state_q <= ST_IDLE;
				ST_FETCH: begin
					ir_q <= rdat;
					addr_q <= faddr;
					inc_q <= pc_q + 16'd2;
					state_q <= ST_DATA;
				end
				ST_DATA: state_q <= (opc == OP_STB) ? ST_RMW : ST_IDLE;
				ST_RMW: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) res_q <= nres;
	end

	assign out_valid = out_valid_q;
	assign program_counter = res_q.program_counter;
	assign cond_codes = res_q.cond_codes;
	assign halted = res_q.halted;
	assign reg_written = res_q.reg_written;
	assign reg_index = res_q.reg_index;
	assign reg_value = res_q.reg_value;
	assign mem_stored = res_q.mem_stored;
	assign read_word = res_q.read_word;

	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> in_stall) else $error("request taken during clear");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> out_free) else $error("result overwritten");
	a_cc_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(cc_q)) else $error("flags not one-hot");
	a_fetch_next: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FETCH |=> state_q == ST_DATA) else $error("fetch sequence");
endmodule
